### rtl/core/smtd_pkg.sv
package smtd_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_DELAY    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WOBBLE_DEPTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LFO_STEP      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWPASS_COEFF = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX       = 3'd5;

    // Register values after reset.
    localparam logic [23:0] BASE_DELAY_RST    = 24'd614400;
    localparam logic [17:0] WOBBLE_DEPTH_RST  = 18'd0;
    localparam logic [31:0] LFO_STEP_RST      = 32'd0;
    localparam logic [15:0] LOWPASS_COEFF_RST = 16'd42539;
    localparam logic [15:0] FEEDBACK_GAIN_RST = 16'd0;
    localparam logic [15:0] WET_MIX_RST       = 16'd0;

    // Mix and feedback limits.
    localparam logic [15:0] MIX_ONE    = 16'd32768;
    localparam logic [15:0] MIX_BYPASS = 16'd33;
    localparam logic [15:0] FB_MAX     = 16'd58982;

    // Step strobes that the sequencer hands to the tap unit and the lanes.
    typedef struct packed {
        logic ld;
        logic lfo_mul;
        logic dly;
        logic pos;
        logic adr;
        logic rd;
        logic ip0;
        logic ip1;
        logic fb0;
        logic fb1;
        logic fb2;
        logic wr;
    } smtd_ctrl_t;

    // Sine of a 32-bit phase angle in Q1.15, from a Q30 Taylor series to the
    // ninth power. Used only to build the constant sine table.
    function automatic logic signed [15:0] sine_q15(input logic [31:0] t);
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] c;
        logic [63:0] s;
        logic        neg;
        neg = t[31];
        u   = {33'd0, t[30:0]};
        if (u > 64'd1073741824)
        begin
            u = 64'd2147483648 - u;
        end
        x  = (u * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        c  = 64'd1073741824 - x2 / 64'd72;
        c  = 64'd1073741824 - ((x2 * c) >> 30) / 64'd42;
        c  = 64'd1073741824 - ((x2 * c) >> 30) / 64'd20;
        c  = 64'd1073741824 - ((x2 * c) >> 30) / 64'd6;
        s  = (((x * c) >> 30) + 64'd16384) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return neg ? -$signed(s[15:0]) : $signed(s[15:0]);
    endfunction

endpackage

### rtl/core/smtd_tap.sv
module smtd_tap #(
    parameter int DELAY_DEPTH         = 65536,
    parameter int SINE_TABLE_SIZE     = 1024,
    parameter int DELAY_FRACTION_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  smtd_pkg::smtd_ctrl_t             ctrl,
    input  logic [23:0]                      base_delay,
    input  logic [17:0]                      wobble_depth,
    input  logic [31:0]                      lfo_step,
    input  logic [$clog2(DELAY_DEPTH)-1:0]   wr_pos,
    input  logic                             wrapped,
    output logic [$clog2(DELAY_DEPTH)-1:0]   rd_addr0,
    output logic [$clog2(DELAY_DEPTH)-1:0]   rd_addr1,
    output logic                             rd_ok0,
    output logic                             rd_ok1,
    output logic [DELAY_FRACTION_BITS-1:0]   frac
);
    import smtd_pkg::*;

    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int FB    = DELAY_FRACTION_BITS;
    localparam int LOG2S = $clog2(SINE_TABLE_SIZE);
    localparam int CW    = ((AW + FB + 1) > 26) ? (AW + FB + 2) : 27;
    localparam int RW    = AW + FB + 2;
    localparam logic signed [CW-1:0] DLY_LO = CW'(1) << FB;
    localparam logic signed [CW-1:0] DLY_HI = CW'(DELAY_DEPTH - 2) << FB;
    localparam logic signed [RW-1:0] SPAN   = RW'(DELAY_DEPTH) << FB;

    typedef logic signed [15:0] sine_arr_t [SINE_TABLE_SIZE];

    // The table size is a power of two, so the index is the top phase bits.
    function automatic sine_arr_t build_sine();
        sine_arr_t tbl;
        for (int k = 0; k < SINE_TABLE_SIZE; k++)
        begin
            tbl[k] = sine_q15(32'(k) << (32 - LOG2S));
        end
        return tbl;
    endfunction

    localparam sine_arr_t SINE_TBL = build_sine();

    logic [31:0]              phase_reg;
    logic signed [15:0]       sine_reg;
    logic signed [34:0]       prod_reg;
    logic [AW+FB-1:0]         delay_reg;
    logic [AW-1:0]            i0_reg;
    logic [AW-1:0]            i1_reg;
    logic [FB-1:0]            frac_reg;
    logic                     ok0_reg;
    logic                     ok1_reg;

    logic signed [19:0]       lfo;
    logic signed [CW-1:0]     dsum;
    logic signed [CW-1:0]     dclamp;
    logic signed [RW-1:0]     rp_raw;
    logic signed [RW-1:0]     rp;
    logic [AW-1:0]            i1;

    always_comb
    begin
        lfo = 20'((prod_reg + 35'sd16384) >>> 15);
        dsum = CW'($signed({1'b0, base_delay})) + CW'(lfo);
        if (dsum < DLY_LO)
        begin
            dclamp = DLY_LO;
        end
        else if (dsum > DLY_HI)
        begin
            dclamp = DLY_HI;
        end
        else
        begin
            dclamp = dsum;
        end
        rp_raw = $signed({2'b00, wr_pos, {FB{1'b0}}}) - $signed({2'b00, delay_reg});
        rp = (rp_raw < 0) ? rp_raw + SPAN : rp_raw;
        i1 = (i0_reg == AW'(DELAY_DEPTH - 1)) ? '0 : i0_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (ctrl.dly)
        begin
            phase_reg <= phase_reg + lfo_step;
        end
    end

    always_ff @(posedge clk)
    begin
        sine_reg <= SINE_TBL[phase_reg[31 -: LOG2S]];
        if (ctrl.lfo_mul)
        begin
            prod_reg <= 35'(sine_reg) * 35'($signed({1'b0, wobble_depth}));
        end
        if (ctrl.dly)
        begin
            delay_reg <= (AW + FB)'(dclamp);
        end
        if (ctrl.pos)
        begin
            i0_reg   <= rp[AW+FB-1:FB];
            frac_reg <= rp[FB-1:0];
        end
        if (ctrl.adr)
        begin
            i1_reg  <= i1;
            ok0_reg <= wrapped || (i0_reg < wr_pos);
            ok1_reg <= wrapped || (i1 < wr_pos);
        end
    end

    assign rd_addr0 = i0_reg;
    assign rd_addr1 = i1_reg;
    assign rd_ok0   = ok0_reg;
    assign rd_ok1   = ok1_reg;
    assign frac     = frac_reg;

endmodule

### rtl/core/smtd_lane.sv
module smtd_lane #(
    parameter int DELAY_DEPTH         = 65536,
    parameter int SAMPLE_BITS         = 24,
    parameter int DELAY_FRACTION_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  smtd_pkg::smtd_ctrl_t                ctrl,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic [$clog2(DELAY_DEPTH)-1:0]      rd_addr0,
    input  logic [$clog2(DELAY_DEPTH)-1:0]      rd_addr1,
    input  logic                                rd_ok0,
    input  logic                                rd_ok1,
    input  logic [DELAY_FRACTION_BITS-1:0]      frac,
    input  logic [$clog2(DELAY_DEPTH)-1:0]      wr_addr,
    input  logic [15:0]                         gain,
    input  logic [15:0]                         coeff,
    input  logic [15:0]                         mix,
    input  logic [15:0]                         mix_inv,
    output logic signed [SAMPLE_BITS-1:0]       dry,
    output logic signed [SAMPLE_BITS-1:0]       wet
);
    import smtd_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int FB = DELAY_FRACTION_BITS;
    localparam int PW = SB + FB + 2;
    localparam int MW = SB + 18;
    localparam logic [FB:0]  FRAC_ONE = (FB + 1)'(1) << FB;
    localparam logic signed [PW-1:0] FRAC_HALF = PW'(1) << (FB - 1);
    localparam logic signed [SB+2:0] SMAX = {4'b0000, {(SB-1){1'b1}}};
    localparam logic signed [SB+2:0] SMIN = {4'b1111, {(SB-1){1'b0}}};

    function automatic logic signed [SB-1:0] sat(input logic signed [SB+2:0] v);
        logic signed [SB+2:0] r;
        r = v;
        if (v > SMAX)
        begin
            r = SMAX;
        end
        else if (v < SMIN)
        begin
            r = SMIN;
        end
        return r[SB-1:0];
    endfunction

    logic signed [SB-1:0] store_mem [DELAY_DEPTH];

    logic signed [SB-1:0] in_reg;
    logic signed [SB-1:0] s0_reg;
    logic signed [SB-1:0] s1_reg;
    logic                 ok0_reg;
    logic                 ok1_reg;
    logic signed [PW-1:0] p0_reg;
    logic signed [MW-1:0] mp0_reg;
    logic signed [SB-1:0] del_reg;
    logic signed [SB-1:0] target_reg;
    logic signed [SB+1:0] adj_reg;
    logic signed [SB-1:0] fb_reg;
    logic signed [SB-1:0] wet_reg;

    logic signed [SB-1:0] s0e;
    logic signed [SB-1:0] s1e;
    logic [FB:0]          w0;
    logic signed [PW-1:0] acc;
    logic signed [MW-1:0] tprod;
    logic signed [SB:0]   diff;
    logic signed [MW-1:0] dprod;
    logic signed [MW-1:0] macc;

    always_comb
    begin
        // Entries not yet written since reset read as silence.
        s0e   = ok0_reg ? s0_reg : '0;
        s1e   = ok1_reg ? s1_reg : '0;
        w0    = FRAC_ONE - {1'b0, frac};
        acc   = p0_reg + PW'(s1e) * PW'($signed({1'b0, frac})) + FRAC_HALF;
        tprod = MW'(del_reg) * MW'($signed({1'b0, gain})) + MW'(32768);
        diff  = (SB + 1)'(target_reg) - (SB + 1)'(fb_reg);
        dprod = MW'(diff) * MW'($signed({1'b0, coeff})) + MW'(32768);
        macc  = mp0_reg + MW'(del_reg) * MW'($signed({1'b0, mix})) + MW'(16384);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            store_mem[wr_addr] <= sat((SB + 3)'(in_reg) + (SB + 3)'(fb_reg));
        end
        if (ctrl.rd)
        begin
            s0_reg <= store_mem[rd_addr0];
            s1_reg <= store_mem[rd_addr1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld)
        begin
            in_reg <= sample;
        end
        if (ctrl.rd)
        begin
            ok0_reg <= rd_ok0;
            ok1_reg <= rd_ok1;
        end
        if (ctrl.ip0)
        begin
            p0_reg  <= PW'(s0e) * PW'($signed({1'b0, w0}));
            mp0_reg <= MW'(in_reg) * MW'($signed({1'b0, mix_inv}));
        end
        if (ctrl.ip1)
        begin
            del_reg <= SB'(acc >>> FB);
        end
        if (ctrl.fb0)
        begin
            target_reg <= SB'(tprod >>> 16);
        end
        if (ctrl.fb1)
        begin
            adj_reg <= (SB + 2)'(dprod >>> 16);
        end
        if (ctrl.wr)
        begin
            wet_reg <= sat((SB + 3)'(macc >>> 15));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_reg <= '0;
        end
        else if (ctrl.fb2)
        begin
            fb_reg <= sat((SB + 3)'(fb_reg) + (SB + 3)'(adj_reg));
        end
    end

    assign dry = in_reg;
    assign wet = wet_reg;

endmodule

### rtl/core/stereo_modulated_tape_delay_core.sv
// Stereo modulated delay with lowpass feedback. Each accepted word carries one
// left/right sample pair and yields exactly one processed pair. A sine LFO swings
// the read position around base_delay (Q16.8 samples, clamped to one sample up to
// DELAY_DEPTH-2 samples); both channel stores are read at the same fractional
// position with linear interpolation, the delayed sample is fed back through a
// gain and a one-pole lowpass, and the output is a dry/wet mix. With wet_mix at
// 33 or below the pair passes unchanged and no state moves. A word's result is
// loaded into the output register once the step sequencer has walked the LFO
// multiply, tap position, store read, interpolation, feedback and mix steps one
// registered step at a time (a bypassed word skips these steps); in_stall is
// high while the sequencer works on a word and while a finished result waits for
// a full output register. The output register lets a new word enter while the
// previous result waits. Stores need no clearing pass: entries not yet written
// since reset read as zero. Write configuration only while no word is in flight.
module stereo_modulated_tape_delay_core #(
    parameter int DELAY_DEPTH         = 65536,
    parameter int SAMPLE_BITS         = 24,
    parameter int SINE_TABLE_SIZE     = 1024,
    parameter int DELAY_FRACTION_BITS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [SAMPLE_BITS-1:0]          left_in,
    input  logic signed [SAMPLE_BITS-1:0]          right_in,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [SAMPLE_BITS-1:0]          left_out,
    output logic signed [SAMPLE_BITS-1:0]          right_out,
    input  logic                                   wr_en,
    input  logic [smtd_pkg::CFG_INDEX_W-1:0]       wr_index,
    input  logic [smtd_pkg::CFG_DATA_W-1:0]        wr_data
);
    import smtd_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int SB = SAMPLE_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LFOM,
        ST_DLY,
        ST_POS,
        ST_ADR,
        ST_RD,
        ST_IP0,
        ST_IP1,
        ST_FB0,
        ST_FB1,
        ST_FB2,
        ST_WR,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic [23:0] base_delay_reg;
    logic [17:0] wobble_depth_reg;
    logic [31:0] lfo_step_reg;
    logic [15:0] lowpass_coeff_reg;
    logic [15:0] feedback_gain_reg;
    logic [15:0] wet_mix_reg;

    logic [AW-1:0]        wp_reg;
    logic                 wrapped_reg;
    logic                 bypass_reg;
    logic                 out_valid_reg;
    logic signed [SB-1:0] left_out_reg;
    logic signed [SB-1:0] right_out_reg;

    smtd_ctrl_t   ctrl;
    logic         in_accept;
    logic         bypass_now;
    logic         out_free;
    logic [15:0]  mix_eff;
    logic [15:0]  mix_inv;
    logic [15:0]  gain_eff;
    logic [16:0]  mix_diff;

    logic [AW-1:0]                  rd_addr0;
    logic [AW-1:0]                  rd_addr1;
    logic                           rd_ok0;
    logic                           rd_ok1;
    logic [DELAY_FRACTION_BITS-1:0] frac;
    logic signed [SB-1:0]           left_dry;
    logic signed [SB-1:0]           left_wet;
    logic signed [SB-1:0]           right_dry;
    logic signed [SB-1:0]           right_wet;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign bypass_now = (wet_mix_reg <= MIX_BYPASS);
    assign out_free   = !out_valid_reg || !out_stall;

    // Mix above unity and feedback above its limit are pinned.
    assign mix_eff  = (wet_mix_reg > MIX_ONE) ? MIX_ONE : wet_mix_reg;
    assign gain_eff = (feedback_gain_reg > FB_MAX) ? FB_MAX : feedback_gain_reg;
    assign mix_diff = {1'b0, MIX_ONE} - {1'b0, mix_eff};
    assign mix_inv  = mix_diff[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_delay_reg    <= BASE_DELAY_RST;
            wobble_depth_reg  <= WOBBLE_DEPTH_RST;
            lfo_step_reg      <= LFO_STEP_RST;
            lowpass_coeff_reg <= LOWPASS_COEFF_RST;
            feedback_gain_reg <= FEEDBACK_GAIN_RST;
            wet_mix_reg       <= WET_MIX_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_BASE_DELAY:    base_delay_reg    <= wr_data[23:0];
                REG_WOBBLE_DEPTH:  wobble_depth_reg  <= wr_data[17:0];
                REG_LFO_STEP:      lfo_step_reg      <= wr_data[31:0];
                REG_LOWPASS_COEFF: lowpass_coeff_reg <= wr_data[15:0];
                REG_FEEDBACK_GAIN: feedback_gain_reg <= wr_data[15:0];
                REG_WET_MIX:       wet_mix_reg       <= wr_data[15:0];
                default:           ;
            endcase
        end
    end

    // The sequencer walks each non-bypassed word through one registered step per cycle.
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.ld    = in_accept;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = bypass_now ? ST_DONE : ST_LFOM;
                end
            end
            ST_LFOM:
            begin
                ctrl.lfo_mul = 1'b1;
                state_next   = ST_DLY;
            end
            ST_DLY:
            begin
                ctrl.dly   = 1'b1;
                state_next = ST_POS;
            end
            ST_POS:
            begin
                ctrl.pos   = 1'b1;
                state_next = ST_ADR;
            end
            ST_ADR:
            begin
                ctrl.adr   = 1'b1;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                ctrl.rd    = 1'b1;
                state_next = ST_IP0;
            end
            ST_IP0:
            begin
                ctrl.ip0   = 1'b1;
                state_next = ST_IP1;
            end
            ST_IP1:
            begin
                ctrl.ip1   = 1'b1;
                state_next = ST_FB0;
            end
            ST_FB0:
            begin
                ctrl.fb0   = 1'b1;
                state_next = ST_FB1;
            end
            ST_FB1:
            begin
                ctrl.fb1   = 1'b1;
                state_next = ST_FB2;
            end
            ST_FB2:
            begin
                ctrl.fb2   = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                ctrl.wr    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, write position and output valid; the merge stage below gathers both lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            bypass_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                bypass_reg <= bypass_now;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (!bypass_reg)
                begin
                    if (wp_reg == AW'(DELAY_DEPTH - 1))
                    begin
                        wp_reg      <= '0;
                        wrapped_reg <= 1'b1;
                    end
                    else
                    begin
                        wp_reg <= wp_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            left_out_reg  <= bypass_reg ? left_dry : left_wet;
            right_out_reg <= bypass_reg ? right_dry : right_wet;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    smtd_tap #(
        .DELAY_DEPTH         (DELAY_DEPTH),
        .SINE_TABLE_SIZE     (SINE_TABLE_SIZE),
        .DELAY_FRACTION_BITS (DELAY_FRACTION_BITS)
    ) u_tap (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .base_delay   (base_delay_reg),
        .wobble_depth (wobble_depth_reg),
        .lfo_step     (lfo_step_reg),
        .wr_pos       (wp_reg),
        .wrapped      (wrapped_reg),
        .rd_addr0     (rd_addr0),
        .rd_addr1     (rd_addr1),
        .rd_ok0       (rd_ok0),
        .rd_ok1       (rd_ok1),
        .frac         (frac)
    );

    smtd_lane #(
        .DELAY_DEPTH         (DELAY_DEPTH),
        .SAMPLE_BITS         (SAMPLE_BITS),
        .DELAY_FRACTION_BITS (DELAY_FRACTION_BITS)
    ) u_lane_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .sample   (left_in),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_ok0   (rd_ok0),
        .rd_ok1   (rd_ok1),
        .frac     (frac),
        .wr_addr  (wp_reg),
        .gain     (gain_eff),
        .coeff    (lowpass_coeff_reg),
        .mix      (mix_eff),
        .mix_inv  (mix_inv),
        .dry      (left_dry),
        .wet      (left_wet)
    );

    smtd_lane #(
        .DELAY_DEPTH         (DELAY_DEPTH),
        .SAMPLE_BITS         (SAMPLE_BITS),
        .DELAY_FRACTION_BITS (DELAY_FRACTION_BITS)
    ) u_lane_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .sample   (right_in),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_ok0   (rd_ok0),
        .rd_ok1   (rd_ok1),
        .frac     (frac),
        .wr_addr  (wp_reg),
        .gain     (gain_eff),
        .coeff    (lowpass_coeff_reg),
        .mix      (mix_eff),
        .mix_inv  (mix_inv),
        .dry      (right_dry),
        .wet      (right_wet)
    );

`ifndef SYNTHESIS
    // A result only appears after the sequencer has finished a word.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output word appeared without a finished word");

    // The write position moves only when a processed word completes.
    a_wp_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg != $past(wp_reg)) |-> $past(state_reg == ST_DONE && !bypass_reg))
        else $error("write position moved outside word completion");

    // A bypassed word never enters the processing steps.
    a_bypass_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LFOM) |-> !bypass_reg)
        else $error("bypassed word entered the processing steps");
`endif

endmodule
